### hdl/bgc_pkg.sv
`timescale 1ns / 1ps

package bgc_pkg;

  // Default width of the internal time arithmetic
  localparam int TIME_BITS_DEF = 32;

  // Configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [1:0] REG_MULTI_CLICK = 2'd2;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [15:0] MULTI_CLICK_RST = 16'd400;

  // Click tally saturation
  localparam logic [7:0] CLICK_MAX = 8'd255;

  // Gesture codes
  localparam logic [2:0] G_NONE   = 3'd0;
  localparam logic [2:0] G_CLICK  = 3'd1;
  localparam logic [2:0] G_DOUBLE = 3'd2;
  localparam logic [2:0] G_TRIPLE = 3'd3;
  localparam logic [2:0] G_MULTI  = 3'd4;
  localparam logic [2:0] G_LONG   = 3'd5;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_pressed;
    logic        take_gesture;
    logic [31:0] hold_threshold_ms;
  } in_item_t;

  typedef struct packed {
    logic        press_edge;
    logic        release_edge;
    logic        is_pressed;
    logic        is_holding;
    logic [2:0]  gesture;
    logic [7:0]  gesture_clicks;
    logic [31:0] press_duration_ms;
    logic        held_enough;
  } out_item_t;

  typedef struct packed {
    logic [15:0] debounce_time_ms;
    logic [15:0] long_press_time_ms;
    logic [15:0] multi_click_time_ms;
  } cfg_t;

endpackage

### hdl/bgc_cfg_regs.sv
`timescale 1ns / 1ps

module bgc_cfg_regs
  import bgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes fall through untouched
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_DEBOUNCE:    cfg_nxt.debounce_time_ms    = cfg_wdata;
        REG_LONG_PRESS:  cfg_nxt.long_press_time_ms  = cfg_wdata;
        REG_MULTI_CLICK: cfg_nxt.multi_click_time_ms = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time_ms    <= DEBOUNCE_RST;
      cfg_r.long_press_time_ms  <= LONG_PRESS_RST;
      cfg_r.multi_click_time_ms <= MULTI_CLICK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/bgc_in_stage.sv
`timescale 1ns / 1ps

module bgc_in_stage
  import bgc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // Stall only while a held request cannot move on
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### hdl/bgc_core.sv
`timescale 1ns / 1ps

module bgc_core
  import bgc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  // Button state
  logic                 raw_level_r, raw_level_nxt;
  logic [TIME_BITS-1:0] raw_change_time_r, raw_change_time_nxt;
  logic                 stable_level_r, stable_level_nxt;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;
  logic [TIME_BITS-1:0] release_time_r, release_time_nxt;
  logic                 long_active_r, long_active_nxt;
  logic [7:0]           click_tally_r, click_tally_nxt;
  logic [2:0]           latched_gesture_r, latched_gesture_nxt;
  logic [7:0]           latched_clicks_r, latched_clicks_nxt;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] dbc_t, lpt_t, mct_t;
  logic [TIME_BITS-1:0] el_raw, el_press, el_rel, el_span;
  logic [2:0]           gest_pre;
  logic [7:0]           clicks_pre;
  logic                 debounced, pe, re;
  logic                 long_pre;
  logic [7:0]           tally_pre, tally_mid;
  logic                 long_hit, click_done;
  logic [2:0]           click_kind;

  // Bring the timestamp and the times into the time width
  assign now_t = TIME_BITS'(item.now_ms);
  assign dbc_t = TIME_BITS'(cfg.debounce_time_ms);
  assign lpt_t = TIME_BITS'(cfg.long_press_time_ms);
  assign mct_t = TIME_BITS'(cfg.multi_click_time_ms);

  // Take clears the latch before the tick is evaluated
  assign gest_pre   = item.take_gesture ? G_NONE : latched_gesture_r;
  assign clicks_pre = item.take_gesture ? 8'd0 : latched_clicks_r;

  // Track the raw level and time its last change
  assign raw_level_nxt       = item.button_pressed;
  assign raw_change_time_nxt = (item.button_pressed != raw_level_r) ? now_t
                                                                   : raw_change_time_r;
  assign el_raw = now_t - raw_change_time_nxt;

  // Accept a change that has persisted for the debounce time
  assign debounced = (stable_level_r != raw_level_nxt) && (el_raw >= dbc_t);
  assign pe        = debounced && raw_level_nxt;
  assign re        = debounced && !raw_level_nxt;

  assign stable_level_nxt = debounced ? raw_level_nxt : stable_level_r;
  assign press_time_nxt   = pe ? now_t : press_time_r;
  assign release_time_nxt = re ? now_t : release_time_r;

  // Any accepted edge ends a long press; a short release counts a click
  assign long_pre = debounced ? 1'b0 : long_active_r;
  always_comb begin
    tally_pre = click_tally_r;
    if (re) begin
      if (long_active_r) begin
        tally_pre = 8'd0;
      end else if (click_tally_r < CLICK_MAX) begin
        tally_pre = click_tally_r + 8'd1;
      end
    end
  end

  // Long press detection
  assign el_press = now_t - press_time_nxt;
  assign long_hit = stable_level_nxt && !long_pre && (el_press >= lpt_t);
  assign long_active_nxt = long_pre || long_hit;
  assign tally_mid = long_hit ? 8'd0 : tally_pre;

  // Close the click sequence once the window has run out
  assign el_rel     = now_t - release_time_nxt;
  assign click_done = !stable_level_nxt && !long_active_nxt && (tally_mid != 8'd0) &&
                      (el_rel >= mct_t);
  assign click_tally_nxt = click_done ? 8'd0 : tally_mid;

  always_comb begin
    case (tally_mid)
      8'd1:    click_kind = G_CLICK;
      8'd2:    click_kind = G_DOUBLE;
      8'd3:    click_kind = G_TRIPLE;
      default: click_kind = G_MULTI;
    endcase
  end

  // Latch a new gesture only when none is pending
  always_comb begin
    latched_gesture_nxt = gest_pre;
    latched_clicks_nxt  = clicks_pre;
    if (gest_pre == G_NONE) begin
      if (long_hit) begin
        latched_gesture_nxt = G_LONG;
        latched_clicks_nxt  = 8'd0;
      end else if (click_done) begin
        latched_gesture_nxt = click_kind;
        latched_clicks_nxt  = tally_mid;
      end
    end
  end

  assign el_span = release_time_nxt - press_time_nxt;

  // Assemble the result of this tick
  always_comb begin
    result.press_edge        = pe;
    result.release_edge      = re;
    result.is_pressed        = stable_level_nxt;
    result.is_holding        = stable_level_nxt && long_active_nxt;
    result.gesture           = latched_gesture_nxt;
    result.gesture_clicks    = latched_clicks_nxt;
    result.press_duration_ms = stable_level_nxt ? 32'(el_press) : 32'(el_span);
    result.held_enough       = stable_level_nxt &&
                               (64'(el_press) >= 64'(item.hold_threshold_ms));
  end

  // Commit the state when the tick moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_level_r       <= 1'b0;
      raw_change_time_r <= '0;
      stable_level_r    <= 1'b0;
      press_time_r      <= '0;
      release_time_r    <= '0;
      long_active_r     <= 1'b0;
      click_tally_r     <= 8'd0;
      latched_gesture_r <= G_NONE;
      latched_clicks_r  <= 8'd0;
    end else if (fire) begin
      raw_level_r       <= raw_level_nxt;
      raw_change_time_r <= raw_change_time_nxt;
      stable_level_r    <= stable_level_nxt;
      press_time_r      <= press_time_nxt;
      release_time_r    <= release_time_nxt;
      long_active_r     <= long_active_nxt;
      click_tally_r     <= click_tally_nxt;
      latched_gesture_r <= latched_gesture_nxt;
      latched_clicks_r  <= latched_clicks_nxt;
    end
  end

endmodule

### hdl/button_gesture_classifier_top.sv
`timescale 1ns / 1ps

// Push-button gesture classifier. Each request on the input channel is one
// sample tick (timestamp in ms, raw level, take flag, hold threshold) and
// yields exactly one result: debounced press/release edges, the pressed and
// holding levels, the pending gesture (click, double, triple, multi or long)
// with its click count, the press duration and the held-for test. A request
// is registered on entry, evaluated against the button state in one pass and
// lands in the result register once it is free, so the block sustains one tick
// per clock while the output is not stalled; out_valid rises as the request
// moves into the result register. A stalled result holds the request behind it,
// which in turn stalls the input. Configuration writes take effect on the next
// tick and are meant for idle periods. Time differences wrap modulo 2^TIME_BITS.

module button_gesture_classifier_top
  import bgc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  cfg_t      cfg;
  logic      advance;
  logic      item_valid;
  in_item_t  item;
  logic      fire;
  out_item_t result;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  bgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bgc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bgc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  // Advance whenever the result register is empty or being drained
  assign advance = !out_valid_r || !out_stall;
  assign fire    = advance && item_valid;

  assign out_valid_nxt = advance ? item_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
